// ===== src/isu_pkg.sv =====
// Shared types and codes for the integer stack unit.
// No dependencies; imported by isu_cell, integer_stack_unit_top and tb_top.
package isu_pkg;

	localparam int unsigned DataW = 32;

	// operation codes
	localparam logic [2:0] K_PUSH  = 3'd0;
	localparam logic [2:0] K_PALL  = 3'd1;
	localparam logic [2:0] K_PINT  = 3'd2;
	localparam logic [2:0] K_POP   = 3'd3;
	localparam logic [2:0] K_SWAP  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// where a cell takes its next value from
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_ABOVE = 2'd1,
		SEL_BELOW = 2'd2,
		SEL_WRAP  = 2'd3
	} sel_t;

	typedef logic signed [DataW-1:0] data_t;

endpackage

// ===== src/isu_cell.sv =====
// One storage cell of the stack chain: a data register with a four-way source mux.
// Depends on isu_pkg.
module isu_cell
	import isu_pkg::*;
(
	input  logic  clk,
	input  sel_t  sel,
	input  data_t above,
	input  data_t below,
	input  data_t wrap,
	output data_t data
);

	data_t data_q;

	always_ff @(posedge clk) begin
		case (sel)
			SEL_ABOVE: data_q <= above;
			SEL_BELOW: data_q <= below;
			SEL_WRAP:  data_q <= wrap;
			default:   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== src/integer_stack_unit_top.sv =====
// Integer stack unit: a chain of isu_cell registers, cell 0 holding the top entry.
// Depends on isu_pkg and isu_cell.
//
// Usage:
//   Operation channel (op_valid / op_stall, kind, push_value): one operation per transfer.
//   Result channel (res_valid / res_stall, status, read_value, value_valid, last):
//   one or more results per operation, the final one marked by last.
//   Push and pop shift the whole cell chain, peek reads the top cell and swap
//   exchanges the top two cells; their result is registered and shows in the
//   cycle after the operation transfer. Print all streams the entries top
//   first, one per cycle, by rotating the occupied cells up by one each cycle
//   and leaving the stack as it was. The operation transfer enters the print
//   state, from which each entry is loaded into the result register; the
//   operation channel stays stalled for the whole stream. A new operation
//   is taken in the cycle its predecessor's last result is taken, so single-result
//   operations sustain one per cycle. A stall on the result channel holds the
//   result register and, through it, stalls the operation channel and freezes a
//   print-all stream. Reset empties the stack (count to zero) and clears the
//   result valid; the cell contents are left as they are.
module integer_stack_unit_top
	import isu_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_stall,
	input  logic [2:0]  kind,
	input  data_t       push_value,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output data_t       read_value,
	output logic        value_valid,
	output logic        last
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_PRINT = 2'b10
	} state_t;

	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  remain_q, remain_d;

	logic           res_valid_q;
	logic [1:0]     status_q;
	data_t          read_value_q;
	logic           value_valid_q;
	logic           last_q;

	logic           out_free, accept, load;
	logic [1:0]     ld_status;
	data_t          ld_value;
	logic           ld_vvalid, ld_last;
	logic           do_push, do_pop, do_swap, do_rot;

	data_t          cell_data [STACK_DEPTH];

	assign out_free = !res_valid_q || !res_stall;
	assign op_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = op_valid && !op_stall;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		remain_d  = remain_q;
		load      = 1'b0;
		ld_status = ST_OK;
		ld_value  = '0;
		ld_vvalid = 1'b0;
		ld_last   = 1'b1;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_swap   = 1'b0;
		do_rot    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					case (kind)
						K_PUSH: begin
							if (count_q == DEPTH_C) begin
								ld_status = ST_FULL;
							end else begin
								do_push = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						K_PALL: begin
							if (count_q != '0) begin
								// results come from the print stream
								load     = 1'b0;
								remain_d = count_q;
								state_d  = S_PRINT;
							end
						end
						K_PINT: begin
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else begin
								ld_value  = cell_data[0];
								ld_vvalid = 1'b1;
							end
						end
						K_POP: begin
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else begin
								do_pop  = 1'b1;
								count_d = count_q - 1'b1;
							end
						end
						K_SWAP: begin
							if (count_q < CW'(2)) begin
								ld_status = ST_SHORT;
							end else begin
								do_swap = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_PRINT: begin
				if (out_free) begin
					load      = 1'b1;
					ld_value  = cell_data[0];
					ld_vvalid = 1'b1;
					ld_last   = (remain_q == CW'(1));
					do_rot    = 1'b1;
					remain_d  = remain_q - 1'b1;
					if (remain_q == CW'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			localparam logic [CW-1:0] IDX_P1 = CW'(gi + 1);
			data_t above_w, below_w;
			sel_t  sel_w;

			if (gi == 0) begin : g_first
				assign above_w = push_value;
			end else begin : g_mid
				assign above_w = cell_data[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_last
				assign below_w = cell_data[gi];
			end else begin : g_up
				assign below_w = cell_data[gi+1];
			end

			always_comb begin
				sel_w = SEL_HOLD;
				if (do_push) begin
					sel_w = SEL_ABOVE;
				end else if (do_pop) begin
					sel_w = SEL_BELOW;
				end else if (do_swap) begin
					if (gi == 0) begin
						sel_w = SEL_BELOW;
					end else if (gi == 1) begin
						sel_w = SEL_ABOVE;
					end
				end else if (do_rot) begin
					// occupied cells move up one; the top wraps to the bottom entry
					if (IDX_P1 < remain_q || IDX_P1 < count_q) begin
						sel_w = (IDX_P1 == count_q) ? SEL_WRAP : SEL_BELOW;
					end else if (IDX_P1 == count_q) begin
						sel_w = SEL_WRAP;
					end
				end
			end

			isu_cell u_cell (
				.clk   (clk),
				.sel   (sel_w),
				.above (above_w),
				.below (below_w),
				.wrap  (cell_data[0]),
				.data  (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q      <= ld_status;
			read_value_q  <= ld_value;
			value_valid_q <= ld_vvalid;
			last_q        <= ld_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign value_valid = value_valid_q;
	assign last        = last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond depth");

	a_print_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRINT |-> (remain_q != '0 && remain_q <= count_q))
		else $error("print counter out of range");

	a_print_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRINT |-> op_stall)
		else $error("operation taken during print stream");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == K_PUSH && count_q != DEPTH_C
		|=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the stack");

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !value_valid |-> read_value == '0)
		else $error("read_value nonzero without data");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for integer_stack_unit_top: push, pop, peek, swap and print-all.
// A driver and a monitor with random idles and stalls check each result against a stack predictor.
// Depends on isu_pkg and integer_stack_unit_top.
module tb_top;
	import isu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned Depth = 64;
	localparam int unsigned OpItems = 430;
	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned DrainCycles = 20;
	localparam logic [2:0] K_FIRST_UNUSED = K_SWAP + 3'd1;
	localparam logic [2:0] K_LAST_CODE = '1;
	localparam data_t MinValue = data_t'(32'h8000_0000);
	localparam data_t MaxValue = data_t'(32'h7FFF_FFFF);

	typedef struct packed {
		logic [2:0] op_kind;
		data_t      op_value;
	} stack_op_t;

	typedef struct packed {
		logic [1:0] status;
		data_t      read_value;
		logic       value_valid;
		logic       last;
	} stack_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       op_valid = 1'b0;
	logic       op_stall;
	logic [2:0] kind = K_PUSH;
	data_t      push_value = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [1:0] status;
	data_t      read_value;
	logic       value_valid;
	logic       last;

	stack_op_t     pending_ops[$];
	stack_result_t expected_results[$];

	// predictor state
	data_t       stack_mem[Depth];
	int unsigned stack_depth = 0;

	// stack depth as seen by the generator, used to shape sequences
	int unsigned gen_depth = 0;
	int unsigned items_queued = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int          op_gap = 0;
	int          stall_left = 0;

	integer_stack_unit_top #(
		.STACK_DEPTH(Depth)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.op_valid(op_valid),
		.op_stall(op_stall),
		.kind(kind),
		.push_value(push_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.status(status),
		.read_value(read_value),
		.value_valid(value_valid),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void expect_result(logic [1:0] st, data_t val, logic vld, logic lst);
		expected_results.push_back('{st, val, vld, lst});
	endfunction

	function automatic void predict_stack_op(logic [2:0] op, data_t value);
		int unsigned n;
		data_t held;
		n = stack_depth;
		case (op)
			K_PUSH: begin
				if (n >= Depth) begin
					expect_result(ST_FULL, '0, 1'b0, 1'b1);
				end else begin
					stack_mem[n] = value;
					stack_depth = n + 1;
					expect_result(ST_OK, '0, 1'b0, 1'b1);
				end
			end
			K_PALL: begin
				if (n == 0) begin
					expect_result(ST_OK, '0, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < n; i++)
						expect_result(ST_OK, stack_mem[n - 1 - i], 1'b1, i == n - 1);
				end
			end
			K_PINT: begin
				if (n == 0)
					expect_result(ST_EMPTY, '0, 1'b0, 1'b1);
				else
					expect_result(ST_OK, stack_mem[n - 1], 1'b1, 1'b1);
			end
			K_POP: begin
				if (n == 0) begin
					expect_result(ST_EMPTY, '0, 1'b0, 1'b1);
				end else begin
					stack_depth = n - 1;
					expect_result(ST_OK, '0, 1'b0, 1'b1);
				end
			end
			K_SWAP: begin
				if (n < 2) begin
					expect_result(ST_SHORT, '0, 1'b0, 1'b1);
				end else begin
					held = stack_mem[n - 1];
					stack_mem[n - 1] = stack_mem[n - 2];
					stack_mem[n - 2] = held;
					expect_result(ST_OK, '0, 1'b0, 1'b1);
				end
			end
			default: begin
				// unused codes leave the stack alone
				expect_result(ST_OK, '0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 25);
	endfunction

	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return MinValue;
			1: return MaxValue;
			2: return '0;
			3: return '1;
			default: return data_t'($urandom());
		endcase
	endfunction

	function automatic logic [2:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return K_PUSH;
		else if (r < 45)
			return K_PALL;
		else if (r < 60)
			return K_PINT;
		else if (r < 80)
			return K_POP;
		else if (r < 95)
			return K_SWAP;
		else
			return 3'($urandom_range(K_FIRST_UNUSED, K_LAST_CODE));
	endfunction

	function automatic void queue_op(logic [2:0] op, data_t value);
		pending_ops.push_back('{op, value});
		items_queued++;
		if (op == K_PUSH && gen_depth < Depth)
			gen_depth++;
		else if (op == K_POP && gen_depth > 0)
			gen_depth--;
	endfunction

	function automatic void queue_fill();
		while (gen_depth < Depth)
			queue_op(K_PUSH, pick_value());
		repeat ($urandom_range(1, 3))
			queue_op(K_PUSH, pick_value());
		queue_op(K_PALL, pick_value());
		queue_op(K_PINT, pick_value());
		queue_op(K_SWAP, pick_value());
	endfunction

	function automatic void queue_drain();
		while (gen_depth > 0) begin
			if ($urandom_range(0, 4) == 0)
				queue_op($urandom_range(0, 1) ? K_PINT : K_SWAP, pick_value());
			else
				queue_op(K_POP, pick_value());
		end
		repeat ($urandom_range(1, 2))
			queue_op(K_POP, pick_value());
		queue_op(K_PINT, pick_value());
		queue_op(K_SWAP, pick_value());
		queue_op(K_PALL, pick_value());
	endfunction

	// operation driver: predicts on each accepted transfer
	always @(posedge clk) begin
		stack_op_t item;
		if (arst_n) begin
			if (op_valid && !op_stall)
				predict_stack_op(kind, push_value);
			if (!op_valid || !op_stall) begin
				if (op_gap > 0) begin
					op_gap--;
					op_valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					item = pending_ops.pop_front();
					op_valid <= 1'b1;
					kind <= item.op_kind;
					push_value <= item.op_value;
					op_gap = pick_gap();
				end else begin
					op_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall generator
	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d read_value %0d value_valid %0b last %0b",
						status, read_value, value_valid, last);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value, read_value);
						mismatches++;
					end
					if (value_valid !== want.value_valid) begin
						$error("value_valid: expected %0b, got %0b", want.value_valid, value_valid);
						mismatches++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
				stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	// watchdog: any transfer on either channel resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((op_valid && !op_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		// empty-stack errors, print-all with nothing held, short swap, unused codes and popping past empty
		queue_op(K_PINT, pick_value());
		queue_op(K_POP, pick_value());
		queue_op(K_SWAP, pick_value());
		queue_op(K_PALL, pick_value());
		queue_op(K_PUSH, MinValue);
		queue_op(K_SWAP, pick_value());
		queue_op(K_PUSH, MaxValue);
		queue_op(K_PINT, '1);
		queue_op(K_SWAP, '0);
		queue_op(K_PALL, MaxValue);
		queue_op(K_PUSH, '0);
		queue_op(K_PUSH, '1);
		queue_op(K_FIRST_UNUSED, '1);
		queue_op(K_FIRST_UNUSED + 3'd1, MinValue);
		queue_op(K_LAST_CODE, MaxValue);
		queue_op(K_PALL, '0);
		queue_op(K_PINT, data_t'(32'h5555_5555));
		repeat (4)
			queue_op(K_POP, pick_value());
		queue_op(K_POP, pick_value());
		queue_op(K_PINT, pick_value());

		// full stack reached at least once
		queue_fill();
		while (items_queued < OpItems) begin
			case ($urandom_range(0, 9))
				0, 1: queue_fill();
				2, 3, 4: queue_drain();
				default: begin
					repeat ($urandom_range(10, 30))
						queue_op(pick_kind(), pick_value());
				end
			endcase
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_ops.size() != 0 || op_valid || expected_results.size() != 0);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
